// ===== src/indexed_list_stack_queue_top_macros.svh =====
// Assertion macros for the indexed list block.
// Used by indexed_list_stack_queue_top; relies on clk and rst in scope.
`ifndef INDEXED_LIST_STACK_QUEUE_TOP_MACROS_SVH
`define INDEXED_LIST_STACK_QUEUE_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset
`define ILSQ_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle
`define ILSQ_CHECK_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ===== src/ilsq_pkg.sv =====
// Shared types and constants for the indexed list block.
// No dependencies; imported by the top level.
package ilsq_pkg;

  // Request codes
  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_APPEND  = 3'd2;
  localparam logic [2:0] OP_POP     = 3'd3;
  localparam logic [2:0] OP_DEQUEUE = 3'd4;

  localparam logic [5:0] CAPACITY_RESET = 6'd32;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [5:0]         index;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic               value_valid;
    logic               accepted;
    logic [5:0]         count;
    logic               empty_res;
    logic               full_res;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAKE,
    ST_GRAB,
    ST_FETCH,
    ST_MOVE,
    ST_PUT,
    ST_DONE
  } state_t;

endpackage

// ===== src/ilsq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ilsq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/indexed_list_stack_queue_top.sv =====
// Indexed list: ordered list of signed 32-bit entries in one RAM, with insert/remove at an
// index, append, pop tail and dequeue head. One request is handled at a time; a small
// sequencer moves entries one slot at a time, a fetch state then a move state, through the
// RAM's single read and single write port. A finished request may wait in the done state
// for the result register to drain. The result register lets the result wait while the
// next request is accepted.
module indexed_list_stack_queue_top #(
  parameter int DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  ilsq_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output ilsq_pkg::rsp_t  rsp,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [5:0]      cfg_data
);
  import ilsq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  state_t state, state_next;

  logic [5:0]  capacity;
  logic [5:0]  cnt;
  logic [5:0]  eff_cap;
  logic [5:0]  pos;
  logic [5:0]  ptr;
  logic [5:0]  last;
  logic        up;
  logic        ok;
  logic        take;
  logic [31:0] val;
  logic [31:0] taken;

  logic        accept;
  logic        ins_req;
  logic        rem_req;
  logic        ins_ok;
  logic        rem_ok;
  logic [5:0]  pos_d;
  logic        rsp_free;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  ilsq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign accept    = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Clamp the capacity register to the usable range
  always_comb begin
    if (capacity == 6'd0) begin
      eff_cap = 6'd1;
    end else if (32'(capacity) > DEPTH) begin
      eff_cap = 6'(DEPTH);
    end else begin
      eff_cap = capacity;
    end
  end

  // Decode the incoming request
  always_comb begin
    ins_req = 1'b0;
    rem_req = 1'b0;
    ins_ok  = 1'b0;
    rem_ok  = 1'b0;
    pos_d   = 6'd0;
    case (req.opcode)
      OP_INSERT: begin
        ins_req = 1'b1;
        pos_d   = req.index;
        ins_ok  = (cnt < eff_cap) && (req.index <= cnt);
      end
      OP_APPEND: begin
        ins_req = 1'b1;
        pos_d   = cnt;
        ins_ok  = cnt < eff_cap;
      end
      OP_REMOVE: begin
        rem_req = 1'b1;
        pos_d   = req.index;
        rem_ok  = req.index < cnt;
      end
      OP_POP: begin
        rem_req = 1'b1;
        pos_d   = cnt - 6'd1;
        rem_ok  = cnt != 6'd0;
      end
      OP_DEQUEUE: begin
        rem_req = 1'b1;
        pos_d   = 6'd0;
        rem_ok  = cnt != 6'd0;
      end
      default: begin
        ins_req = 1'b0;
        rem_req = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (ins_req && ins_ok) begin
            state_next = (cnt > pos_d) ? ST_FETCH : ST_PUT;
          end else if (rem_req && rem_ok) begin
            state_next = ST_TAKE;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_TAKE: state_next = ST_GRAB;
      ST_GRAB: state_next = (ptr < last) ? ST_FETCH : ST_DONE;
      ST_FETCH: state_next = ST_MOVE;
      ST_MOVE: begin
        if (up) begin
          state_next = ((ptr - 6'd1) > pos) ? ST_FETCH : ST_PUT;
        end else begin
          state_next = ({1'b0, ptr} + 7'd1 < {1'b0, last}) ? ST_FETCH : ST_DONE;
        end
      end
      ST_PUT: state_next = ST_DONE;
      ST_DONE: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Drive RAM ports and handshake from the state
  always_comb begin
    req_stall = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = AW'(ptr);
    ram_wdata = ram_rdata;
    ram_raddr = AW'(pos);
    case (state)
      ST_IDLE: req_stall = 1'b0;
      ST_TAKE: ram_raddr = AW'(pos);
      ST_FETCH: ram_raddr = up ? AW'(ptr - 6'd1) : AW'(ptr + 6'd1);
      ST_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(ptr);
        ram_wdata = ram_rdata;
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(pos);
        ram_wdata = val;
      end
      default: req_stall = 1'b1;
    endcase
  end

  // Control state: sequencer, count, capacity, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= 6'd0;
      capacity  <= CAPACITY_RESET;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      // Raise the result once the register is free, drop it after its transfer
      if ((state == ST_DONE) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_GRAB: cnt <= cnt - 6'd1;
        ST_PUT:  cnt <= cnt + 6'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          pos   <= pos_d;
          val   <= req.value;
          up    <= ins_req;
          ok    <= (ins_req && ins_ok) || (rem_req && rem_ok);
          take  <= rem_ok && ((req.opcode == OP_POP) || (req.opcode == OP_DEQUEUE));
          ptr   <= ins_req ? cnt : pos_d;
          last  <= cnt - 6'd1;
          taken <= 32'd0;
        end
      end
      ST_GRAB: taken <= ram_rdata;
      ST_MOVE: ptr <= up ? (ptr - 6'd1) : (ptr + 6'd1);
      ST_DONE: begin
        if (rsp_free) begin
          rsp.value_out   <= take ? taken : 32'd0;
          rsp.value_valid <= take;
          rsp.accepted    <= ok;
          rsp.count       <= cnt;
          rsp.empty_res   <= cnt == 6'd0;
          rsp.full_res    <= cnt >= eff_cap;
        end
      end
      default: ptr <= ptr;
    endcase
  end

  `include "indexed_list_stack_queue_top_macros.svh"

  `ILSQ_CHECK(a_cnt_bound, 32'(cnt) <= DEPTH, "entry count above depth")
  `ILSQ_CHECK(a_take_ok, !rsp_valid || !rsp.value_valid || rsp.accepted, "value without accept")
  `ILSQ_CHECK(a_zero_out, !rsp_valid || rsp.value_valid || (rsp.value_out == 32'd0), "stray value")
  `ILSQ_CHECK_NEXT(a_busy, accept, req_stall, "second transfer while busy")

endmodule
